>>> rtl/tlsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsc_pkg
// Shared types, constants and float helpers for the texel level statistics core.
// ----------------------------------------------------------------------------
package tlsc_pkg;

  // default counter width (counts saturate at 2**CountBitsDef)
  localparam int unsigned CountBitsDef = 24;

  // reset value of the alpha threshold: 0.5
  localparam logic [31:0] AlphaThrRst = 32'h3F00_0000;

  // Rec.709 luma weights, Q0.16, summing to 1.0
  localparam logic signed [16:0] WeightRed   = 17'sd13933;
  localparam logic signed [16:0] WeightGreen = 17'sd46871;
  localparam logic signed [16:0] WeightBlue  = 17'sd4732;

  localparam int unsigned ProdW  = 49;  // Q16.16 times Q0.16
  localparam int unsigned TermW  = 34;  // per-texel luma term, Q.8
  localparam int unsigned QDepth = 4;   // front-to-back queue depth

  // one classified texel on its way to the accumulator
  typedef struct packed {
    logic signed [TermW-1:0] term;
    logic                    finite;
    logic                    covered;
    logic                    last;
    logic [31:0]             red;
    logic [31:0]             green;
    logic [31:0]             blue;
    logic [31:0]             alpha;
  } tlsc_entry_t;

  function automatic logic f_nan(input logic [31:0] b);
    return b[30:0] > 31'h7F80_0000;
  endfunction

  function automatic logic f_zero(input logic [31:0] b);
    return b[30:0] == 31'd0;
  endfunction

  function automatic logic f_finite(input logic [31:0] b);
    return b[30:23] != 8'hFF;
  endfunction

  // monotonic key for ordered compares
  function automatic logic [31:0] f_key(input logic [31:0] b);
    return b[31] ? ~b : (b | 32'h8000_0000);
  endfunction

  function automatic logic f_ge(input logic [31:0] a, input logic [31:0] b);
    logic res;
    if (f_nan(a) || f_nan(b)) res = 1'b0;
    else if (f_zero(a) && f_zero(b)) res = 1'b1;
    else res = f_key(a) >= f_key(b);
    return res;
  endfunction

  // equality of two finite values, minus zero equals plus zero
  function automatic logic f_equal(input logic [31:0] a, input logic [31:0] b);
    return (a == b) || (f_zero(a) && f_zero(b));
  endfunction

  // float32 to signed Q16.16, truncating toward zero, saturating
  function automatic logic signed [31:0] to_q16(input logic [31:0] b);
    logic [7:0]  e;
    logic [23:0] m;
    logic [7:0]  rs;
    logic [31:0] mag;
    logic signed [31:0] res;
    e   = b[30:23];
    m   = {1'b1, b[22:0]};
    rs  = 8'd134 - e;
    mag = '0;
    if (e >= 8'd142) mag = 32'h8000_0000;
    else if (e >= 8'd134) mag = {8'd0, m} << e[2:0] - 3'd6;
    else if (rs > 8'd31) mag = '0;
    else mag = {8'd0, m} >> rs[4:0];
    if (e == 8'd0) res = '0;
    else if (b[31]) res = -signed'(mag);
    else if (mag[31]) res = 32'sh7FFF_FFFF;
    else res = signed'(mag);
    return res;
  endfunction

endpackage

>>> rtl/tlsc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsc_front
// Accepts texels, classifies them, converts to fixed point, forms luma term.
// ----------------------------------------------------------------------------
module tlsc_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [127:0]       in_data_i,
  input  logic               in_last_i,
  input  logic               q_ready_i,
  output logic               q_push_o,
  output tlsc_pkg::tlsc_entry_t q_entry_o
);
  import tlsc_pkg::*;

  logic [31:0] thr_q;
  logic        adv;

  // stage 1: classify and convert
  logic               s1_valid_q, s1_fin_q, s1_cov_q, s1_last_q;
  logic [127:0]       s1_raw_q;
  logic signed [31:0] s1_r_q, s1_g_q, s1_b_q;
  // stage 2: weighted products
  logic               s2_valid_q, s2_fin_q, s2_cov_q, s2_last_q;
  logic [127:0]       s2_raw_q;
  logic signed [ProdW-1:0] s2_pr_q, s2_pg_q, s2_pb_q;

  logic signed [50:0] y_sum;
  logic signed [59:0] v;

  logic [31:0] ch_r, ch_g, ch_b, ch_a;
  assign ch_r = in_data_i[31:0];
  assign ch_g = in_data_i[63:32];
  assign ch_b = in_data_i[95:64];
  assign ch_a = in_data_i[127:96];

  // pipeline moves unless the last stage is held by a full queue
  assign adv        = !s2_valid_q || q_ready_i;
  assign in_ready_o = adv;

  // alpha threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= AlphaThrRst;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_fin_q  <= f_finite(ch_r) && f_finite(ch_g) && f_finite(ch_b) && f_finite(ch_a);
      s1_cov_q  <= f_ge(ch_a, thr_q);
      s1_last_q <= in_last_i;
      s1_raw_q  <= in_data_i;
      s1_r_q    <= to_q16(ch_r);
      s1_g_q    <= to_q16(ch_g);
      s1_b_q    <= to_q16(ch_b);
      s2_fin_q  <= s1_fin_q;
      s2_cov_q  <= s1_cov_q;
      s2_last_q <= s1_last_q;
      s2_raw_q  <= s1_raw_q;
      s2_pr_q   <= s1_r_q * WeightRed;
      s2_pg_q   <= s1_g_q * WeightGreen;
      s2_pb_q   <= s1_b_q * WeightBlue;
    end
  end

  // luma term: floor((Y*255 + 2^23) / 2^24)
  assign y_sum = 51'(s2_pr_q) + 51'(s2_pg_q) + 51'(s2_pb_q);
  assign v     = (60'(y_sum) <<< 8) - 60'(y_sum) + 60'sd8388608;

  assign q_push_o          = s2_valid_q && q_ready_i;
  assign q_entry_o.term    = v[57:24];
  assign q_entry_o.finite  = s2_fin_q;
  assign q_entry_o.covered = s2_cov_q;
  assign q_entry_o.last    = s2_last_q;
  assign q_entry_o.red     = s2_raw_q[31:0];
  assign q_entry_o.green   = s2_raw_q[63:32];
  assign q_entry_o.blue    = s2_raw_q[95:64];
  assign q_entry_o.alpha   = s2_raw_q[127:96];

endmodule

>>> rtl/tlsc_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsc_fifo
// Short queue of classified texels between front and back.
// ----------------------------------------------------------------------------
module tlsc_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  tlsc_pkg::tlsc_entry_t wdata_i,
  output logic                  ready_o,
  input  logic                  pop_i,
  output logic                  valid_o,
  output tlsc_pkg::tlsc_entry_t rdata_o
);
  import tlsc_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  tlsc_entry_t         mem_q [QDepth];
  logic [PtrW-1:0]     wptr_q, rptr_q;
  logic [PtrW:0]       cnt_q;

  assign ready_o = cnt_q != (PtrW+1)'(QDepth);
  assign valid_o = cnt_q != '0;
  assign rdata_o = mem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wptr_q] <= wdata_i;
  end

endmodule

>>> rtl/tlsc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsc_back
// Accumulates statistics and forms the level result with a serial divider.
// ----------------------------------------------------------------------------
module tlsc_back #(
  parameter int unsigned COUNT_BITS = tlsc_pkg::CountBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  q_valid_i,
  output logic                  q_pop_o,
  input  tlsc_pkg::tlsc_entry_t q_entry_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [103:0]          out_data_o
);
  import tlsc_pkg::*;

  localparam int unsigned CntW = COUNT_BITS + 1;

  localparam logic [1:0] ST_ACC  = 2'd0;
  localparam logic [1:0] ST_PREP = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_DONE = 2'd3;

  logic [1:0] st_q, st_d;

  // statistics
  logic signed [63:0] luma_q, luma_d;
  logic [CntW-1:0]    cov_q, cov_d, fin_q, fin_d, skip_q, skip_d;
  logic [31:0]        first_q [4];
  logic               have_q, have_d, same_q, same_d, grab;

  // divider
  logic [63:0]     num_m_q, num_c_q;
  logic [CntW-1:0] rem_m_q, rem_c_q, sh_m, sh_c;
  logic [5:0]      step_q;
  logic            neg_q;
  logic [63:0]     mag;

  // result
  logic            out_valid_q;
  logic [103:0]    out_q;
  logic [31:0]     mean;
  logic [16:0]     cov_res;
  logic [63:0]     fin_w, skip_w;

  assign q_pop_o = (st_q == ST_ACC) && q_valid_i;

  // statistics update and state sequencing
  always_comb begin
    st_d   = st_q;
    luma_d = luma_q;
    cov_d  = cov_q;
    fin_d  = fin_q;
    skip_d = skip_q;
    have_d = have_q;
    same_d = same_q;
    grab   = 1'b0;
    case (st_q)
      ST_ACC: begin
        if (q_pop_o) begin
          if (!q_entry_i.finite) begin
            if (!skip_q[COUNT_BITS]) skip_d = skip_q + 1'b1;
          end else begin
            if (!have_q) begin
              grab   = 1'b1;
              have_d = 1'b1;
            end else if (!f_equal(q_entry_i.red,   first_q[0]) ||
                         !f_equal(q_entry_i.green, first_q[1]) ||
                         !f_equal(q_entry_i.blue,  first_q[2]) ||
                         !f_equal(q_entry_i.alpha, first_q[3])) begin
              same_d = 1'b0;
            end
            if (!fin_q[COUNT_BITS]) begin
              luma_d = luma_q + 64'(q_entry_i.term);
              if (q_entry_i.covered) cov_d = cov_q + 1'b1;
              fin_d = fin_q + 1'b1;
            end
          end
          if (q_entry_i.last) st_d = ST_PREP;
        end
      end
      ST_PREP: st_d = ST_DIV;
      ST_DIV:  if (step_q == 6'd63) st_d = ST_DONE;
      ST_DONE: begin
        if (!out_valid_q) begin
          st_d   = ST_ACC;
          luma_d = '0;
          cov_d  = '0;
          fin_d  = '0;
          skip_d = '0;
          have_d = 1'b0;
          same_d = 1'b1;
        end
      end
      default: st_d = ST_ACC;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= ST_ACC;
      luma_q <= '0;
      cov_q  <= '0;
      fin_q  <= '0;
      skip_q <= '0;
      have_q <= 1'b0;
      same_q <= 1'b1;
    end else begin
      st_q   <= st_d;
      luma_q <= luma_d;
      cov_q  <= cov_d;
      fin_q  <= fin_d;
      skip_q <= skip_d;
      have_q <= have_d;
      same_q <= same_d;
    end
  end

  // first finite texel of the level
  always_ff @(posedge clk_i) begin
    if (grab) begin
      first_q[0] <= q_entry_i.red;
      first_q[1] <= q_entry_i.green;
      first_q[2] <= q_entry_i.blue;
      first_q[3] <= q_entry_i.alpha;
    end
  end

  // restoring division, one quotient bit per cycle for mean and coverage
  assign mag  = luma_q[63] ? 64'(-luma_q) : 64'(luma_q);
  assign sh_m = {rem_m_q[CntW-2:0], num_m_q[63]};
  assign sh_c = {rem_c_q[CntW-2:0], num_c_q[63]};

  always_ff @(posedge clk_i) begin
    if (st_q == ST_PREP) begin
      neg_q   <= luma_q[63];
      num_m_q <= mag + 64'(fin_q >> 1);
      num_c_q <= (64'(cov_q) << 16) + 64'(fin_q >> 1);
      rem_m_q <= '0;
      rem_c_q <= '0;
      step_q  <= '0;
    end else if (st_q == ST_DIV) begin
      step_q <= step_q + 1'b1;
      if (sh_m >= fin_q) begin
        rem_m_q <= sh_m - fin_q;
        num_m_q <= {num_m_q[62:0], 1'b1};
      end else begin
        rem_m_q <= sh_m;
        num_m_q <= {num_m_q[62:0], 1'b0};
      end
      if (sh_c >= fin_q) begin
        rem_c_q <= sh_c - fin_q;
        num_c_q <= {num_c_q[62:0], 1'b1};
      end else begin
        rem_c_q <= sh_c;
        num_c_q <= {num_c_q[62:0], 1'b0};
      end
    end
  end

  // saturate and pack the result
  always_comb begin
    if (fin_q == '0) mean = '0;
    else if (neg_q) mean = (num_m_q > 64'h8000_0000) ? 32'h8000_0000 : 32'(-num_m_q);
    else mean = (num_m_q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : num_m_q[31:0];
    cov_res = (fin_q == '0) ? 17'd0 : num_c_q[16:0];
    fin_w   = 64'(fin_q);
    skip_w  = 64'(skip_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (st_q == ST_DONE && !out_valid_q) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == ST_DONE && !out_valid_q) begin
      out_q <= {3'b000,
                have_q && same_q && f_zero(first_q[0]) && f_zero(first_q[1]) &&
                  f_zero(first_q[2]),
                have_q && same_q,
                fin_w[24:0], skip_w[24:0], cov_res, mean};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

>>> rtl/texel_level_statistics_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_level_statistics_core
// Mean Rec.709 luma, alpha coverage and constancy over one level of texels.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one RGBA texel (four float32 patterns) per transfer, tlast
//   marks the final texel of a level. Output stream: one result per level.
//   cfg_we_i/cfg_wdata_i write the float32 alpha threshold; write only
//   while the block is idle.
// Timing:
//   Texels are taken one per cycle unless a full queue stalls the front; a
//   two-stage front (classify/convert, weight products; the luma term is
//   formed at the queue input) feeds a four-entry queue into the accumulator,
//   which consumes one texel per cycle while it is accumulating.
//   After the last texel a prepare state and then the serial divider (one
//   quotient bit per cycle) run before the result is registered; the
//   accumulator takes no new texel until the result is in the output register.
// Reset: statistics cleared, threshold returns to 0.5.
// Stall: a held result keeps the accumulator waiting; the front then fills
//   the queue and drops s_axis_tready.
// ----------------------------------------------------------------------------
module texel_level_statistics_core #(
  parameter int unsigned COUNT_BITS = tlsc_pkg::CountBitsDef
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [31:0]  cfg_wdata_i,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [127:0] s_axis_tdata,  // red, green, blue, alpha
  input  logic         s_axis_tlast,  // last_texel
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [103:0] m_axis_tdata   // luma mean, coverage fraction,
                                      // non_finite_count, finite_count,
                                      // is_constant, is_black, zero pad
);
  import tlsc_pkg::*;

  tlsc_entry_t push_entry, pop_entry;
  logic        push, pop, q_ready, q_valid;

  tlsc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (s_axis_tdata),
    .in_last_i   (s_axis_tlast),
    .q_ready_i   (q_ready),
    .q_push_o    (push),
    .q_entry_o   (push_entry)
  );

  tlsc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_entry),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .rdata_o (pop_entry)
  );

  tlsc_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_pop_o     (pop),
    .q_entry_i   (pop_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule

>>> rtl/tlsc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlsc_checker
// Port-level checks on the result stream of the statistics core.
// ----------------------------------------------------------------------------
module tlsc_checker (
  input logic         clk_i,
  input logic         rst_ni,
  input logic         m_axis_tvalid,
  input logic         m_axis_tready,
  input logic [103:0] m_axis_tdata
);

  // a stalled result holds its value
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // black implies constant
  a_black: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[100] |-> m_axis_tdata[99])
    else $error("black without constant");

  // empty level gives zero mean, coverage and no constancy
  a_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[98:74] == 25'd0 |->
      m_axis_tdata[48:0] == 49'd0 && !m_axis_tdata[99])
    else $error("nonzero statistics for empty level");

  // coverage never exceeds one
  a_cov: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[48:32] <= 17'd65536)
    else $error("coverage above one");

endmodule

bind texel_level_statistics_core tlsc_checker u_tlsc_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

>>> verif/texel_level_statistics_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// texel_level_statistics_core_tb
// Drives levels of RGBA texels into the core, predicts each level summary
// (mean luma, alpha coverage, counts, constant and black flags) and checks
// every result transfer in order against the prediction.
// ----------------------------------------------------------------------------
module texel_level_statistics_core_tb;

  localparam int unsigned CountBits = tlsc_pkg::CountBitsDef;

  typedef struct {
    logic [31:0] luma_avg;
    logic [16:0] coverage;
    logic [24:0] skipped;
    logic [24:0] finite;
    logic        constant;
    logic        black;
  } level_summary_t;

  // --------------------------------------------------------------------------
  // Level statistics predictor and summary scoreboard
  // --------------------------------------------------------------------------
  class level_scoreboard;
    logic [31:0]    threshold;
    longint         luma_acc;
    longint unsigned covered, finite, skipped;
    logic [31:0]    first_px [4];
    bit             have_first, all_same;
    level_summary_t pending[$];
    int unsigned    mismatches;

    function new();
      threshold  = tlsc_pkg::AlphaThrRst;
      mismatches = 0;
      clear();
    endfunction

    function void clear();
      luma_acc = 0; covered = 0; finite = 0; skipped = 0;
      have_first = 0; all_same = 1;
      for (int i = 0; i < 4; i++) first_px[i] = '0;
    endfunction

    function bit is_nan(logic [31:0] b);
      return b[30:0] > 31'h7F80_0000;
    endfunction

    function bit is_zero(logic [31:0] b);
      return b[30:0] == 31'd0;
    endfunction

    function bit is_finite(logic [31:0] b);
      return b[30:23] != 8'hFF;
    endfunction

    function bit same_value(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 0;
      return (a == b) || (is_zero(a) && is_zero(b));
    endfunction

    function logic [31:0] order_key(logic [31:0] b);
      return b[31] ? ~b : (b | 32'h8000_0000);
    endfunction

    function bit at_or_above(logic [31:0] a, logic [31:0] b);
      if (is_nan(a) || is_nan(b)) return 0;
      if (is_zero(a) && is_zero(b)) return 1;
      return order_key(a) >= order_key(b);
    endfunction

    // float32 -> Q16.16, truncating, saturating
    function longint fixed_q16(logic [31:0] b);
      int e, sh;
      longint unsigned mag, m;
      e = b[30:23];
      if (e == 0) return 0;
      sh = e - 134;
      m = {40'd0, 1'b1, b[22:0]};
      if (sh >= 8) mag = 64'd1 << 31;
      else if (sh >= 0) mag = m << sh;
      else if (-sh > 31) mag = 0;
      else mag = m >> (-sh);
      if (b[31]) begin
        if (mag > (64'd1 << 31)) mag = 64'd1 << 31;
        return -longint'(mag);
      end
      if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
      return longint'(mag);
    endfunction

    function longint luma_q8(logic [31:0] r, logic [31:0] g, logic [31:0] b);
      longint y, v;
      longint unsigned u;
      y = 13933 * fixed_q16(r) + 46871 * fixed_q16(g) + 4732 * fixed_q16(b);
      v = y * 255 + (longint'(1) << 23);
      if (v >= 0) return longint'(longint'(unsigned'(v)) >>> 24);
      u = unsigned'(-v);
      return -longint'((u + (64'd1 << 24) - 1) >> 24);
    endfunction

    // note one accepted texel
    function void add_texel(logic [127:0] px, bit last);
      logic [31:0] ch [4];
      bit ok;
      level_summary_t s;
      longint unsigned mag, q, lim;
      bit neg;
      lim = 64'd1 << CountBits;
      ok = 1;
      for (int i = 0; i < 4; i++) begin
        ch[i] = px[32*i +: 32];
        if (!is_finite(ch[i])) ok = 0;
      end
      if (!ok) begin
        if (skipped < lim) skipped++;
      end else begin
        if (!have_first) begin
          for (int i = 0; i < 4; i++) first_px[i] = ch[i];
          have_first = 1;
        end else if (all_same) begin
          for (int i = 0; i < 4; i++)
            if (!same_value(ch[i], first_px[i])) all_same = 0;
        end
        if (finite < lim) begin
          luma_acc += luma_q8(ch[0], ch[1], ch[2]);
          if (at_or_above(ch[3], threshold)) covered++;
          finite++;
        end
      end
      if (!last) return;
      s.luma_avg = '0;
      s.coverage = '0;
      if (finite > 0) begin
        neg = luma_acc < 0;
        mag = neg ? unsigned'(-luma_acc) : unsigned'(luma_acc);
        q = (mag + finite / 2) / finite;
        if (neg) begin
          if (q > 64'h8000_0000) q = 64'h8000_0000;
          s.luma_avg = 32'(-q);
        end else begin
          if (q > 64'h7FFF_FFFF) q = 64'h7FFF_FFFF;
          s.luma_avg = 32'(q);
        end
        s.coverage = 17'((covered * 65536 + finite / 2) / finite);
      end
      s.skipped  = 25'(skipped);
      s.finite   = 25'(finite);
      s.constant = have_first && all_same;
      s.black    = s.constant && is_zero(first_px[0]) && is_zero(first_px[1])
                   && is_zero(first_px[2]);
      pending = {pending, s};
      clear();
    endfunction

    function void report(string what, longint unsigned exp_v, longint unsigned act_v);
      mismatches++;
      if (mismatches <= 10)
        $display("mismatch %s: expected %h, got %h", what, exp_v, act_v);
    endfunction

    // check one result transfer against the oldest expectation
    function void check_summary(logic [103:0] d);
      level_summary_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 0, d[63:0]);
        return;
      end
      e = pending.pop_front();
      if (d[31:0]  !== e.luma_avg)  report("luma_avg", e.luma_avg, d[31:0]);
      if (d[48:32] !== e.coverage)  report("coverage", e.coverage, d[48:32]);
      if (d[73:49] !== e.skipped)   report("non_finite_count", e.skipped, d[73:49]);
      if (d[98:74] !== e.finite)    report("finite_count", e.finite, d[98:74]);
      if (d[99]    !== e.constant)  report("is_constant", e.constant, d[99]);
      if (d[100]   !== e.black)     report("is_black", e.black, d[100]);
    endfunction
  endclass

  logic         clk_i = 0;
  logic         rst_ni = 0;
  logic         cfg_we_i = 0;
  logic [31:0]  cfg_wdata_i = '0;
  logic         s_axis_tvalid = 0;
  logic         s_axis_tready;
  logic [127:0] s_axis_tdata = '0;
  logic         s_axis_tlast = 0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 0;
  logic [103:0] m_axis_tdata;

  level_scoreboard sb = new();
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  bit  hold_off = 0;

  texel_level_statistics_core dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #50ms;
    $display("texel_level_statistics_core_tb NOT OK");
    $finish;
  end

  // receiver: random stalls, plus a long hold-off when asked
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_summary(m_axis_tdata);
    m_axis_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rand_channel();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 30) return $urandom;
    if (k < 45) return {1'($urandom), 8'($urandom_range(112, 135)), 23'($urandom)};
    if (k < 55) return {1'($urandom), 31'd0};
    if (k < 60) return {1'($urandom), 8'hFF, ($urandom_range(1) ? 23'd0 : 23'($urandom))};
    if (k < 65) return {1'($urandom), 8'd0, 23'($urandom)};
    if (k < 70) return {1'($urandom), 8'($urandom_range(142, 254)), 23'($urandom)};
    return {1'b0, 8'($urandom_range(117, 127)), 23'($urandom)};
  endfunction

  // valid stays up between back-to-back transfers; dropped only when idling
  task automatic send_texel(logic [127:0] px, bit last);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.add_texel(px, last);
  endtask

  task automatic wait_idle();
    int n;
    n = 0;
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0 && n < 200000) begin
      @(posedge clk_i);
      n++;
    end
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [31:0] v);
    wait_idle();
    cfg_we_i    <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 0;
    sb.threshold = v;
  endtask

  // a level of random texels; sometimes constant
  task automatic send_level(int len);
    logic [127:0] base, px;
    bit flat;
    base = {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
    flat = $urandom_range(3) == 0;
    for (int i = 0; i < len; i++) begin
      px = flat ? base : {rand_channel(), rand_channel(), rand_channel(), rand_channel()};
      if (flat && $urandom_range(5) == 0) px[32*$urandom_range(3) +: 32] ^= 32'h8000_0000;
      if (flat && $urandom_range(15) == 0) px = ~px;
      send_texel(px, i == len - 1);
    end
  endtask

  localparam logic [31:0] FOne = 32'h3F80_0000;
  localparam logic [31:0] FNan = 32'h7FC0_0000;
  localparam logic [31:0] FInf = 32'h7F80_0000;

  initial begin
    int sent;
    int len;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, zero signs, non-finite, empty level, saturation
    send_texel({FOne, FOne, FOne, FOne}, 1);
    send_texel({FOne, 32'h0, 32'h8000_0000, 32'h0}, 0);
    send_texel({32'h0, 32'h8000_0000, 32'h0, 32'h0}, 1);
    send_texel({FOne, FNan, FOne, FOne}, 0);
    send_texel({FInf, FOne, FOne, FOne}, 1);
    send_texel({32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF}, 0);
    send_texel({32'h3F00_0000, 32'h7F7F_FFFF, 32'h7F7F_FFFF, 32'h7F7F_FFFF}, 1);
    send_texel({32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF, 32'hFF7F_FFFF}, 1);
    send_texel({32'h0000_0001, 32'h807F_FFFF, 32'h3700_0000, 32'hBF00_0000}, 0);
    send_texel({32'h3EFF_FFFF, 32'h3F00_0000, 32'h3F00_0001, 32'h3780_0000}, 1);
    send_texel({FOne, 32'hFFFF_FFFF, FOne, FOne}, 0);
    send_texel({FOne, FOne, FOne, FOne}, 0);
    send_texel({32'h0, FOne, FOne, FOne}, 1);
    send_texel({32'h8000_0000, 32'h0, 32'h0, 32'h0}, 1);
    write_threshold(32'h0);
    send_texel({32'h8000_0000, FOne, FOne, FOne}, 0);
    send_texel({32'h0, FOne, FOne, FOne}, 1);
    write_threshold(FNan);
    send_texel({FOne, FOne, FOne, FOne}, 1);
    write_threshold(32'hFFFF_FFFF);
    send_texel({FOne, FOne, FOne, FOne}, 1);
    write_threshold(32'hFF7F_FFFF);
    send_texel({FOne, FOne, FOne, 32'hBF80_0000}, 1);

    // long receiver hold-off while texels keep arriving
    write_threshold(tlsc_pkg::AlphaThrRst);
    hold_off = 1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        for (int k = 0; k < 6; k++) send_level(4);
        s_axis_tvalid <= 0;
        @(posedge clk_i);
      end
    join

    // random phases with varying idling and thresholds
    sent = 0;
    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 69; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 69; end
        default: begin send_idle_pct = 28; recv_stall_pct = 28; end
      endcase
      write_threshold(phase == 7 ? 32'h0 : rand_channel());
      for (int lv = 0; lv < 13; lv++) begin
        len = ($urandom_range(9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
        send_level(len);
        sent += len;
      end
    end

    wait_idle();
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("texel_level_statistics_core_tb OK");
    end else begin
      $display("texel_level_statistics_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/tlsc_pkg.sv
rtl/tlsc_front.sv
rtl/tlsc_fifo.sv
rtl/tlsc_back.sv
rtl/texel_level_statistics_core.sv
rtl/tlsc_checker.sv
verif/texel_level_statistics_core_tb.sv
